// ===== hdl/text_record_parser_dedup_defines.svh =====
// Assertion macros for the record parser.
// Both macros check on the rising clock edge and hold off while reset is low.
`ifndef TEXT_RECORD_PARSER_DEDUP_DEFINES_SVH
`define TEXT_RECORD_PARSER_DEDUP_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle check: prop must hold at every clock edge.
`define TRPD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("trpd assertion failed");

// Next-cycle check: when ante holds, cons must hold in the cycle after.
`define TRPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("trpd assertion failed");

`else

`define TRPD_ASSERT(lbl, clk, rst_n, prop)
`define TRPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/trpd_pkg.sv =====
`timescale 1ns / 1ps

package trpd_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int ID_WIDTH_DEF    = 32;

	localparam int RECORD_ID_W  = 32;
	localparam int SAVED_W      = 7;
	localparam int IGNORED_W    = 32;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LF   = 8'h0a;
	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_SP   = 8'h20;

	localparam int ID_RADIX = 10;

	typedef enum logic [1:0] {
		VERDICT_SAVED     = 2'd0,
		VERDICT_DUP       = 2'd1,
		VERDICT_MALFORMED = 2'd2,
		VERDICT_FULL      = 2'd3
	} verdict_t;

	// controller -> datapath
	typedef struct packed {
		logic parse;        // input beat accepted
		logic search_start; // reset search index
		logic search_step;  // one table read / compare
		logic commit;       // write verdict, update counters, clear line
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic line_end;     // current input beat ends a non-empty line
		logic line_valid;   // pending line has id and info
		logic search_done;  // all stored ids compared
		logic out_free;     // output register can take a result
	} sts_t;

endpackage

// ===== hdl/trpd_in_if.sv =====
`timescale 1ns / 1ps

interface trpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_input;

	modport source (output valid, output char_byte, output end_of_input, input ready);
	modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

// ===== hdl/trpd_out_if.sv =====
`timescale 1ns / 1ps

interface trpd_out_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         verdict;
	logic [trpd_pkg::RECORD_ID_W-1:0]   record_id;
	logic [trpd_pkg::SAVED_W-1:0]       saved_total;
	logic [trpd_pkg::IGNORED_W-1:0]     ignored_total;

	modport source (output valid, output verdict, output record_id, output saved_total,
		output ignored_total, input ready);
	modport sink   (input valid, input verdict, input record_id, input saved_total,
		input ignored_total, output ready);
endinterface

// ===== hdl/trpd_ctrl.sv =====
`timescale 1ns / 1ps

module trpd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  trpd_pkg::sts_t   sts,
	output trpd_pkg::cmd_t   cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SRCH,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   rdy_q;
	logic   acc;

	assign acc      = in_valid && rdy_q;
	assign in_ready = rdy_q;

	always_comb begin
		cmd              = '0;
		cmd.parse        = acc;
		cmd.search_start = acc && sts.line_end && sts.line_valid;
		cmd.search_step  = (state_q == S_SRCH);
		cmd.commit       = (state_q == S_COMMIT) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rdy_q   <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc && sts.line_end) begin
						rdy_q   <= 1'b0;
						state_q <= sts.line_valid ? S_SRCH : S_COMMIT;
					end
				end
				S_SRCH: begin
					if (sts.search_done) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						rdy_q   <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					rdy_q   <= 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== hdl/trpd_dp.sv =====
`timescale 1ns / 1ps

module trpd_dp #(
	parameter int TABLE_DEPTH = trpd_pkg::TABLE_DEPTH_DEF,
	parameter int ID_WIDTH    = trpd_pkg::ID_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [7:0]                        char_byte,
	input  logic                              end_of_input,
	input  trpd_pkg::cmd_t                    cmd,
	output trpd_pkg::sts_t                    sts,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        verdict,
	output logic [trpd_pkg::RECORD_ID_W-1:0]  record_id,
	output logic [trpd_pkg::SAVED_W-1:0]      saved_total,
	output logic [trpd_pkg::IGNORED_W-1:0]    ignored_total
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_ID    = 3'd1,
		PH_WAIT  = 3'd2,
		PH_INFO  = 3'd3,
		PH_SKIP  = 3'd4
	} phase_t;

	phase_t                           phase_q;
	logic [ID_WIDTH-1:0]              acc_q;
	logic                             seen_q;
	logic [CW-1:0]                    cnt_q;
	logic [trpd_pkg::IGNORED_W-1:0]   ign_q;
	logic [CW-1:0]                    idx_q;
	logic                             cmp_vld_q;
	logic                             dup_q;
	logic [ID_WIDTH-1:0]              rd_data_s1;
	logic [ID_WIDTH-1:0]              mem [TABLE_DEPTH];
	logic                             out_vld_q;
	logic [1:0]                       verdict_q;
	logic [trpd_pkg::RECORD_ID_W-1:0] rec_id_q;
	logic [trpd_pkg::SAVED_W-1:0]     saved_q;

	logic                             is_blank;
	logic                             is_digit;
	logic                             parse_upd;
	logic [ID_WIDTH-1:0]              acc_next;
	logic                             full;
	logic                             save;
	trpd_pkg::verdict_t               vd;
	logic [CW-1:0]                    cnt_next;
	logic [trpd_pkg::IGNORED_W-1:0]   ign_next;
	logic [63:0]                      id_wide;
	logic [31:0]                      cnt_wide;

	assign is_blank  = (char_byte == trpd_pkg::CH_SP) || (char_byte == trpd_pkg::CH_TAB);
	assign is_digit  = (char_byte >= trpd_pkg::CH_ZERO) && (char_byte <= trpd_pkg::CH_NINE);
	assign parse_upd = cmd.parse && !end_of_input && (char_byte != trpd_pkg::CH_CR) &&
		(char_byte != trpd_pkg::CH_LF);

	// acc * 10 + digit, as two shifts and adds, wrapping at ID_WIDTH
	assign acc_next = {acc_q[ID_WIDTH-4:0], 3'b000} + {acc_q[ID_WIDTH-2:0], 1'b0} +
		ID_WIDTH'(char_byte - trpd_pkg::CH_ZERO);

	always_comb begin
		sts             = '0;
		sts.line_end    = (phase_q != PH_START) &&
			(end_of_input || (char_byte == trpd_pkg::CH_LF));
		sts.line_valid  = (phase_q == PH_INFO) && seen_q;
		sts.search_done = (idx_q >= cnt_q) && !cmp_vld_q;
		sts.out_free    = !out_vld_q || out_ready;
	end

	// verdict of the pending line
	always_comb begin
		full     = (32'(cnt_q) >= 32'(TABLE_DEPTH));
		save     = 1'b0;
		if (!sts.line_valid) begin
			vd = trpd_pkg::VERDICT_MALFORMED;
		end else if (dup_q) begin
			vd = trpd_pkg::VERDICT_DUP;
		end else if (full) begin
			vd = trpd_pkg::VERDICT_FULL;
		end else begin
			vd   = trpd_pkg::VERDICT_SAVED;
			save = 1'b1;
		end
		cnt_next = save ? cnt_q + CW'(1) : cnt_q;
		if (save || (ign_q == '1)) begin
			ign_next = ign_q;
		end else begin
			ign_next = ign_q + trpd_pkg::IGNORED_W'(1);
		end
		id_wide  = 64'(acc_q);
		cnt_wide = 32'(cnt_next);
	end

	// line parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			acc_q   <= '0;
			seen_q  <= 1'b0;
		end else if (cmd.commit) begin
			phase_q <= PH_START;
			acc_q   <= '0;
			seen_q  <= 1'b0;
		end else if (parse_upd) begin
			case (phase_q)
				PH_START, PH_ID: begin
					phase_q <= PH_ID;
					if (is_blank) begin
						if (seen_q) begin
							phase_q <= PH_WAIT;
						end
					end else if (is_digit) begin
						seen_q <= 1'b1;
						acc_q  <= acc_next;
					end else begin
						phase_q <= PH_SKIP;
					end
				end
				PH_WAIT: begin
					if (!is_blank) begin
						phase_q <= PH_INFO;
					end
				end
				PH_INFO, PH_SKIP: begin
				end
				default: begin
					phase_q <= PH_SKIP;
				end
			endcase
		end
	end

	// search sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			ign_q     <= '0;
			idx_q     <= '0;
			cmp_vld_q <= 1'b0;
			dup_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.search_start) begin
				idx_q     <= '0;
				cmp_vld_q <= 1'b0;
				dup_q     <= 1'b0;
			end else if (cmd.search_step) begin
				if (idx_q < cnt_q) begin
					idx_q     <= idx_q + CW'(1);
					cmp_vld_q <= 1'b1;
				end else begin
					cmp_vld_q <= 1'b0;
				end
				if (cmp_vld_q && (rd_data_s1 == acc_q)) begin
					dup_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				cnt_q     <= cnt_next;
				ign_q     <= ign_next;
				dup_q     <= 1'b0;
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// id table, one read port and one write port, registered read
	always_ff @(posedge clk) begin
		if (cmd.search_step && (idx_q < cnt_q)) begin
			rd_data_s1 <= mem[idx_q[AW-1:0]];
		end
		if (cmd.commit && save) begin
			mem[cnt_q[AW-1:0]] <= acc_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			verdict_q <= vd;
			rec_id_q  <= id_wide[trpd_pkg::RECORD_ID_W-1:0];
			saved_q   <= cnt_wide[trpd_pkg::SAVED_W-1:0];
		end
	end

	assign out_valid     = out_vld_q;
	assign verdict       = verdict_q;
	assign record_id     = rec_id_q;
	assign saved_total   = saved_q;
	assign ignored_total = ign_q;

endmodule

// ===== hdl/text_record_parser_dedup.sv =====
`timescale 1ns / 1ps
// channel  | dir | payload                                          | beat
// ---------+-----+--------------------------------------------------+------------------
// in_ch    | in  | char_byte, end_of_input                          | one text byte
// out_ch   | out | verdict, record_id, saved_total, ignored_total   | one line verdict
//
// A byte that does not end a line leaves in_ch.ready high.
// A line end drops in_ch.ready; a well-formed line then searches the id table, reading
// each saved id in turn, then commits; a malformed line goes straight to the commit.
// The commit waits while a previous verdict sits unread in the output register.
// arst_n clears line state and counters; the id table is not cleared, only
// entries below the saved count are ever read.
`include "text_record_parser_dedup_defines.svh"

module text_record_parser_dedup #(
	parameter int TABLE_DEPTH = trpd_pkg::TABLE_DEPTH_DEF,
	parameter int ID_WIDTH    = trpd_pkg::ID_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	trpd_in_if.sink  in_ch,
	trpd_out_if.source out_ch
);

	// controller <-> datapath
	trpd_pkg::cmd_t cmd;
	trpd_pkg::sts_t sts;

	// sequencer: idle / table search / commit
	trpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// parser, id table, counters and result register
	trpd_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ID_WIDTH    (ID_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_byte     (in_ch.char_byte),
		.end_of_input  (in_ch.end_of_input),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.verdict       (out_ch.verdict),
		.record_id     (out_ch.record_id),
		.saved_total   (out_ch.saved_total),
		.ignored_total (out_ch.ignored_total)
	);

	// no input beat is taken while a line is being finished
	`TRPD_ASSERT(a_commit_blocks_in, clk, arst_n, !(cmd.commit && in_ch.ready))
	`TRPD_ASSERT(a_search_blocks_in, clk, arst_n, !(cmd.search_step && in_ch.ready))
	// a verdict never overwrites one that has not been taken
	`TRPD_ASSERT(a_commit_slot_free, clk, arst_n, !cmd.commit || sts.out_free)
	// every commit shows up on the output next cycle
	`TRPD_ASSERT_NEXT(a_commit_shows, clk, arst_n, cmd.commit, out_ch.valid)

endmodule
